/* src/assert_macros.svh */
// assertion macros shared by the maze walker rtl
// expects signals named clk and rst_n in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define GMD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition that must never be seen outside reset
`define GMD_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* src/gmd_pkg.sv */
// types, constants and helpers for the grid maze depth-first walker
// no dependencies; used by every other file of the block except assert_macros.svh
package gmd_pkg;

    // grid and stack geometry
    localparam int GRID_SIDE   = 8;
    localparam int STACK_DEPTH = 64;
    localparam int COORD_W     = 3;
    localparam int CELL_COUNT  = GRID_SIDE * GRID_SIDE;
    localparam int CELL_AW     = $clog2(CELL_COUNT);
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W       = STACK_AW + 1;

    localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(GRID_SIDE - 1);

    // request operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_RUN   = 1'b1;

    typedef enum logic [1:0] {
        KIND_OPEN  = 2'd0,
        KIND_WALL  = 2'd1,
        KIND_START = 2'd2,
        KIND_GOAL  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        STAT_PATH   = 3'd0,
        STAT_GOAL   = 3'd1,
        STAT_SAME   = 3'd2,
        STAT_NOPATH = 3'd3,
        STAT_OVF    = 3'd4
    } status_t;

    // neighbour order: down, up, right, left
    typedef enum logic [1:0] {
        DIR_DOWN  = 2'd0,
        DIR_UP    = 2'd1,
        DIR_RIGHT = 2'd2,
        DIR_LEFT  = 2'd3
    } dir_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CUR_RD,
        S_CUR_CHK,
        S_NB_RD,
        S_NB_CHK,
        S_BACK,
        S_POP_WAIT,
        S_PATH_RD,
        S_PATH_OUT,
        S_SAME,
        S_NOPATH,
        S_OVF
    } state_t;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } pos_t;

    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [1:0]         cell_kind;
    } req_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] path_row;
        logic [COORD_W-1:0] path_col;
        logic [2:0]         status;
        logic               last;
    } rsp_item_t;

    // controller to datapath
    typedef struct packed {
        logic    cell_wr;
        logic    run_init;
        logic    cell_rd;
        logic    rd_nb;
        logic    mark;
        logic    dir_clr;
        logic    dir_inc;
        logic    push;
        logic    pop;
        logic    load_cur;
        logic    path_rd;
        logic    out_path;
        logic    out_stat;
        status_t stat_code;
    } gmd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cur_goal;
        logic nb_ok;
        logic nb_free;
        logic dir_last;
        logic count_zero;
        logic count_one;
        logic count_full;
        logic path_last;
        logic out_free;
    } gmd_sts_t;

    // linear cell index of a grid position
    function automatic logic [CELL_AW-1:0] cell_index(pos_t p);
        logic [CELL_AW-1:0] r;
        logic [CELL_AW-1:0] c;
        r = CELL_AW'(p.row);
        c = CELL_AW'(p.col);
        return CELL_AW'(r * CELL_AW'(GRID_SIDE)) + c;
    endfunction

endpackage

/* src/gmd_req_if.sv */
// request channel: cell writes and run starts
// depends on gmd_pkg
interface gmd_req_if;
    import gmd_pkg::*;

    logic      valid;
    logic      ready;
    req_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/gmd_rsp_if.sv */
// result channel: path cells and run status
// depends on gmd_pkg
interface gmd_rsp_if;
    import gmd_pkg::*;

    logic      valid;
    logic      ready;
    rsp_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/gmd_ctrl.sv */
// run sequencer of the maze walker: visit, neighbour scan, backtrack, emit
// depends on gmd_pkg; drives the command struct of gmd_datapath
module gmd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_op,
    output logic              req_ready,
    input  gmd_pkg::gmd_sts_t sts,
    output gmd_pkg::gmd_cmd_t cmd
);
    import gmd_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_op == OP_RUN)
                begin
                    state_next = S_CUR_RD;
                end
            end
            S_CUR_RD:
            begin
                state_next = S_CUR_CHK;
            end
            S_CUR_CHK:
            begin
                if (sts.cur_goal)
                begin
                    state_next = sts.count_zero ? S_SAME : S_PATH_RD;
                end
                else
                begin
                    state_next = S_NB_RD;
                end
            end
            S_NB_RD:
            begin
                if (sts.nb_ok)
                begin
                    state_next = S_NB_CHK;
                end
                else if (sts.dir_last)
                begin
                    state_next = S_BACK;
                end
            end
            S_NB_CHK:
            begin
                if (sts.nb_free)
                begin
                    state_next = sts.count_full ? S_OVF : S_CUR_RD;
                end
                else
                begin
                    state_next = sts.dir_last ? S_BACK : S_NB_RD;
                end
            end
            S_BACK:
            begin
                if (sts.count_zero)
                begin
                    state_next = S_NOPATH;
                end
                else
                begin
                    // popping the only entry returns to the start directly
                    state_next = sts.count_one ? S_CUR_RD : S_POP_WAIT;
                end
            end
            S_POP_WAIT:
            begin
                state_next = S_CUR_RD;
            end
            S_PATH_RD:
            begin
                state_next = S_PATH_OUT;
            end
            S_PATH_OUT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.path_last ? S_IDLE : S_PATH_RD;
                end
            end
            S_SAME, S_NOPATH, S_OVF:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd           = '0;
        cmd.stat_code = STAT_PATH;
        req_ready     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.cell_wr  = (req_op == OP_WRITE);
                    cmd.run_init = (req_op == OP_RUN);
                end
            end
            S_CUR_RD:
            begin
                cmd.cell_rd = 1'b1;
            end
            S_CUR_CHK:
            begin
                cmd.mark    = 1'b1;
                cmd.dir_clr = 1'b1;
            end
            S_NB_RD:
            begin
                if (sts.nb_ok)
                begin
                    cmd.cell_rd = 1'b1;
                    cmd.rd_nb   = 1'b1;
                end
                else if (!sts.dir_last)
                begin
                    cmd.dir_inc = 1'b1;
                end
            end
            S_NB_CHK:
            begin
                if (sts.nb_free)
                begin
                    cmd.push = !sts.count_full;
                end
                else if (!sts.dir_last)
                begin
                    cmd.dir_inc = 1'b1;
                end
            end
            S_BACK:
            begin
                cmd.pop = !sts.count_zero;
            end
            S_POP_WAIT:
            begin
                cmd.load_cur = 1'b1;
            end
            S_PATH_RD:
            begin
                cmd.path_rd = 1'b1;
            end
            S_PATH_OUT:
            begin
                cmd.out_path = sts.out_free;
            end
            S_SAME:
            begin
                cmd.out_stat  = sts.out_free;
                cmd.stat_code = STAT_SAME;
            end
            S_NOPATH:
            begin
                cmd.out_stat  = sts.out_free;
                cmd.stat_code = STAT_NOPATH;
            end
            S_OVF:
            begin
                cmd.out_stat  = sts.out_free;
                cmd.stat_code = STAT_OVF;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* src/gmd_datapath.sv */
// datapath of the maze walker: grid memory, visited marks, path stack,
// position and direction registers and the result register; depends on gmd_pkg
`include "assert_macros.svh"

module gmd_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  gmd_pkg::req_item_t wr_item,
    input  gmd_pkg::gmd_cmd_t  cmd,
    output gmd_pkg::gmd_sts_t  sts,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output gmd_pkg::rsp_item_t rsp_data
);
    import gmd_pkg::*;

    // memories
    kind_t cell_mem [CELL_COUNT];
    pos_t  stack_mem [STACK_DEPTH];

    kind_t cell_rd_reg;
    pos_t  stack_rd_reg;

    // walk state
    pos_t                  cur_reg;
    pos_t                  start_reg;
    dir_t                  dir_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      k_reg;
    logic [CELL_COUNT-1:0] visited_reg;

    // result register
    logic               out_valid_reg;
    pos_t               out_pos_reg;
    status_t            out_status_reg;
    logic               out_last_reg;

    pos_t                nb;
    logic                nb_ok;
    logic [CELL_AW-1:0]  nb_idx;
    logic [CELL_AW-1:0]  cur_idx;
    logic [CELL_AW-1:0]  wr_idx;
    logic [CELL_AW-1:0]  cell_rd_addr;
    logic [STACK_AW-1:0] pop_addr;
    logic [STACK_AW-1:0] stack_rd_addr;
    logic                stack_rd_en;
    logic                count_one;
    logic                path_last;
    logic                out_free;
    logic                wr_on_grid;

    // neighbour in the current scan direction, off-grid flagged
    always_comb
    begin
        nb    = cur_reg;
        nb_ok = 1'b0;
        case (dir_reg)
            DIR_DOWN:
            begin
                nb_ok  = (cur_reg.row != COORD_MAX);
                nb.row = cur_reg.row + COORD_W'(1);
            end
            DIR_UP:
            begin
                nb_ok  = (cur_reg.row != '0);
                nb.row = cur_reg.row - COORD_W'(1);
            end
            DIR_RIGHT:
            begin
                nb_ok  = (cur_reg.col != COORD_MAX);
                nb.col = cur_reg.col + COORD_W'(1);
            end
            default:
            begin
                nb_ok  = (cur_reg.col != '0);
                nb.col = cur_reg.col - COORD_W'(1);
            end
        endcase
    end

    assign nb_idx     = cell_index(nb);
    assign cur_idx    = cell_index(cur_reg);
    assign wr_idx     = cell_index(pos_t'{row: wr_item.row, col: wr_item.col});
    assign wr_on_grid = (wr_item.row <= COORD_MAX) && (wr_item.col <= COORD_MAX);

    assign count_one = (count_reg == CNT_W'(1));
    assign path_last = (CNT_W'(k_reg + CNT_W'(1)) == count_reg);
    assign out_free  = !out_valid_reg || rsp_ready;

    // status back to the controller
    always_comb
    begin
        sts.cur_goal   = (cell_rd_reg == KIND_GOAL);
        sts.nb_ok      = nb_ok;
        sts.nb_free    = (cell_rd_reg != KIND_WALL) && !visited_reg[nb_idx];
        sts.dir_last   = (dir_reg == DIR_LEFT);
        sts.count_zero = (count_reg == '0);
        sts.count_one  = count_one;
        sts.count_full = (count_reg == CNT_W'(STACK_DEPTH));
        sts.path_last  = path_last;
        sts.out_free   = out_free;
    end

    // grid memory, one write or one read a cycle
    assign cell_rd_addr = cmd.rd_nb ? nb_idx : cur_idx;

    always_ff @(posedge clk)
    begin
        if (cmd.cell_wr && wr_on_grid)
        begin
            cell_mem[wr_idx] <= kind_t'(wr_item.cell_kind);
        end
        if (cmd.cell_rd)
        begin
            cell_rd_reg <= cell_mem[cell_rd_addr];
        end
    end

    // path stack: push at the top, read below the top on a pop or in order on emit
    assign pop_addr      = STACK_AW'(count_reg - CNT_W'(2));
    assign stack_rd_addr = cmd.path_rd ? k_reg[STACK_AW-1:0] : pop_addr;
    assign stack_rd_en   = cmd.path_rd || (cmd.pop && !count_one);

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stack_mem[count_reg[STACK_AW-1:0]] <= nb;
        end
        if (stack_rd_en)
        begin
            stack_rd_reg <= stack_mem[stack_rd_addr];
        end
    end

    // walk control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg     <= '0;
            start_reg   <= '0;
            dir_reg     <= DIR_DOWN;
            count_reg   <= '0;
            k_reg       <= '0;
            visited_reg <= '0;
        end
        else
        begin
            if (cmd.cell_wr && wr_on_grid && wr_item.cell_kind == KIND_START)
            begin
                start_reg <= '{row: wr_item.row, col: wr_item.col};
            end

            if (cmd.run_init)
            begin
                visited_reg <= '0;
            end
            else if (cmd.mark)
            begin
                visited_reg[cur_idx] <= 1'b1;
            end

            if (cmd.run_init)
            begin
                cur_reg <= start_reg;
            end
            else if (cmd.push)
            begin
                cur_reg <= nb;
            end
            else if (cmd.pop && count_one)
            begin
                cur_reg <= start_reg;
            end
            else if (cmd.load_cur)
            begin
                cur_reg <= stack_rd_reg;
            end

            if (cmd.run_init)
            begin
                count_reg <= '0;
            end
            else if (cmd.push)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.pop)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end

            if (cmd.run_init)
            begin
                k_reg <= '0;
            end
            else if (cmd.out_path)
            begin
                k_reg <= k_reg + CNT_W'(1);
            end

            if (cmd.dir_clr)
            begin
                dir_reg <= DIR_DOWN;
            end
            else if (cmd.dir_inc)
            begin
                dir_reg <= dir_t'(dir_reg + 2'd1);
            end
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_path || cmd.out_stat)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_path)
        begin
            out_pos_reg    <= stack_rd_reg;
            out_status_reg <= path_last ? STAT_GOAL : STAT_PATH;
            out_last_reg   <= path_last;
        end
        else if (cmd.out_stat)
        begin
            out_pos_reg    <= cur_reg;
            out_status_reg <= cmd.stat_code;
            out_last_reg   <= 1'b1;
        end
    end

    assign rsp_valid         = out_valid_reg;
    assign rsp_data.path_row = out_pos_reg.row;
    assign rsp_data.path_col = out_pos_reg.col;
    assign rsp_data.status   = out_status_reg;
    assign rsp_data.last     = out_last_reg;

    // checks
    `GMD_ASSERT(a_count_bound, count_reg <= CNT_W'(STACK_DEPTH), "stack count above depth")
    `GMD_ASSERT(a_push_step,
        cmd.push |=> (count_reg == CNT_W'($past(count_reg) + CNT_W'(1))),
        "push did not grow the stack by one")
    `GMD_ASSERT(a_last_status,
        out_valid_reg |-> (out_last_reg == (out_status_reg != STAT_PATH)),
        "last flag disagrees with status")
    `GMD_ASSERT_NEVER(a_pop_empty, cmd.pop && count_reg == '0, "pop on an empty stack")

endmodule

/* src/grid_maze_dfs_path_unit.sv */
// top level of the grid maze depth-first walker
// depends on gmd_pkg, gmd_req_if, gmd_rsp_if, gmd_ctrl and gmd_datapath
//
//  channel  dir  payload                              role
//  req      in   op, row, col, cell_kind              cell write or run start
//  rsp      out  path_row, path_col, status, last     path cell or run status
//
// a cell write is taken in the idle state; a run visits a cell with a read and a check, tries
// each on-grid neighbour with a read and a check and skips an off-grid one, backtracks
// to the start or via a pop wait to a stacked cell (then visited again), and emits each path
// cell by a stack read and an output step, or a status result; each memory has one read port
// requests are refused during a run; a stalled result holds the walk at its emitting step;
// reset clears the control state and the visited marks, not the memories
module grid_maze_dfs_path_unit (
    input logic       clk,
    input logic       rst_n,
    gmd_req_if.sink   req,
    gmd_rsp_if.source rsp
);
    import gmd_pkg::*;

    gmd_cmd_t cmd;
    gmd_sts_t sts;

    // sequencer
    gmd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req.data.op),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // storage and result register
    gmd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_item   (req.data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .rsp_data  (rsp.data)
    );

endmodule
